// ===== design/ssi_pkg.sv =====
// ----------------------------------------------------------------------------
// ssi_pkg: shared constants and types of the scattering source integral
// Field widths, reset values and the term word passed from the front
// pipeline to the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssi_pkg;

    localparam int DIR_BITS        = 16;
    localparam int WEIGHT_BITS     = 16;
    localparam int AREA_BITS       = 16;
    localparam int FACES_PER_CELL  = 4;
    localparam int ILLUM_BITS_DEF  = 24;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int SUM_BITS        = 64;
    localparam int RESULT_BITS     = 32;
    // six direction components and the weight, ahead of the face intensities
    localparam int HEAD_BITS       = 6 * DIR_BITS + WEIGHT_BITS;

    localparam logic [AREA_BITS-1:0] INV_AREA_RESET = 16'd5215;

    // one weighted term, ready to be summed
    typedef struct packed {
        logic                last;
        logic [SUM_BITS-1:0] term;
    } ssi_entry_t;

endpackage

`default_nettype wire

// ===== design/ssi_front.sv =====
// ----------------------------------------------------------------------------
// ssi_front: per-direction term pipeline
// Five stages: dot product, rounding and face mean, phase factor,
// scaled mean, weighted term. Stalls as a whole when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_front import ssi_pkg::*; #(
    parameter int ILLUM_BITS = ILLUM_BITS_DEF,
    parameter int DATA_BITS  = ((HEAD_BITS + FACES_PER_CELL * ILLUM_BITS + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DATA_BITS-1:0] s_tdata,
    input  wire logic                 s_tlast,
    output logic                      entry_valid,
    input  wire logic                 entry_ready,
    output ssi_entry_t                entry
);

    localparam int PROD_BITS = 2 * DIR_BITS;
    localparam int DOT_BITS  = PROD_BITS + 2;
    localparam int M_BITS    = 18;
    localparam int G_BITS    = 21;
    localparam int FSUM_BITS = ILLUM_BITS + 2;
    localparam int GM_BITS   = G_BITS + ILLUM_BITS + 1;
    localparam int P_BITS    = GM_BITS - 14;
    localparam int T_BITS    = P_BITS + WEIGHT_BITS;

    logic advance;

    logic signed [DIR_BITS-1:0]  tx, ty, tz, qx, qy, qz;
    logic signed [PROD_BITS-1:0] px_next, py_next, pz_next;
    logic [FSUM_BITS-1:0]        fsum_next;

    logic                        v1_reg, last1_reg;
    logic signed [PROD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic [FSUM_BITS-1:0]        fsum1_reg;
    logic [WEIGHT_BITS-1:0]      w1_reg;

    logic signed [DOT_BITS-1:0]  dot;
    logic [DOT_BITS-1:0]         mag;
    logic [PROD_BITS:0]          mag_rnd;
    logic [FSUM_BITS-1:0]        mean_rnd;
    logic [FSUM_BITS-1:0]        mean_full;

    logic                        v2_reg, last2_reg;
    logic [M_BITS-1:0]           m2_reg;
    logic [ILLUM_BITS-1:0]       mean2_reg;
    logic [WEIGHT_BITS-1:0]      w2_reg;

    logic [2*M_BITS-1:0]         mm;
    logic [2*M_BITS:0]           pre;
    logic [2*M_BITS+1:0]         tri3;

    logic                        v3_reg, last3_reg;
    logic [G_BITS-1:0]           g3_reg;
    logic [ILLUM_BITS-1:0]       mean3_reg;
    logic [WEIGHT_BITS-1:0]      w3_reg;

    logic [GM_BITS-1:0]          gm;

    logic                        v4_reg, last4_reg;
    logic [P_BITS-1:0]           p4_reg;
    logic [WEIGHT_BITS-1:0]      w4_reg;

    logic                        v5_reg, last5_reg;
    logic [T_BITS-1:0]           t5_reg;

    assign advance  = !v5_reg || entry_ready;
    assign s_tready = advance;

    // stage 1: direction products and face sum
    assign tx = s_tdata[0*DIR_BITS +: DIR_BITS];
    assign ty = s_tdata[1*DIR_BITS +: DIR_BITS];
    assign tz = s_tdata[2*DIR_BITS +: DIR_BITS];
    assign qx = s_tdata[3*DIR_BITS +: DIR_BITS];
    assign qy = s_tdata[4*DIR_BITS +: DIR_BITS];
    assign qz = s_tdata[5*DIR_BITS +: DIR_BITS];

    assign px_next = tx * qx;
    assign py_next = ty * qy;
    assign pz_next = tz * qz;

    always_comb begin
        fsum_next = '0;
        for (int i = 0; i < FACES_PER_CELL; i++) begin
            fsum_next = fsum_next
                      + FSUM_BITS'(s_tdata[HEAD_BITS + i*ILLUM_BITS +: ILLUM_BITS]);
        end
    end

    // stage 2: |dot| rounded to Q.14, rounded face mean
    assign dot = {{2{px_reg[PROD_BITS-1]}}, px_reg}
               + {{2{py_reg[PROD_BITS-1]}}, py_reg}
               + {{2{pz_reg[PROD_BITS-1]}}, pz_reg};
    assign mag       = dot[DOT_BITS-1] ? DOT_BITS'(-dot) : DOT_BITS'(dot);
    assign mag_rnd   = {1'b0, mag[PROD_BITS-1:0]} + (PROD_BITS+1)'(8192);
    assign mean_rnd  = fsum1_reg + FSUM_BITS'(FACES_PER_CELL / 2);
    assign mean_full = FSUM_BITS'(mean_rnd / FACES_PER_CELL);

    // stage 3: phase factor 3(1+m^2)/4 in Q.14
    assign mm   = m2_reg * m2_reg;
    assign pre  = {1'b0, mm} + (2*M_BITS+1)'(29'h1000_0000);
    assign tri3 = {pre, 1'b0} + {1'b0, pre} + (2*M_BITS+2)'(32768);

    // stage 4: factor times mean, back to intensity scale
    assign gm = GM_BITS'(g3_reg) * GM_BITS'(mean3_reg) + GM_BITS'(8192);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            pz_reg    <= pz_next;
            fsum1_reg <= fsum_next;
            w1_reg    <= s_tdata[6*DIR_BITS +: WEIGHT_BITS];
            last1_reg <= s_tlast;

            m2_reg    <= mag_rnd[PROD_BITS-1:14];
            mean2_reg <= mean_full[ILLUM_BITS-1:0];
            w2_reg    <= w1_reg;
            last2_reg <= last1_reg;

            g3_reg    <= tri3[2*M_BITS:16];
            mean3_reg <= mean2_reg;
            w3_reg    <= w2_reg;
            last3_reg <= last2_reg;

            p4_reg    <= gm[GM_BITS-1:14];
            w4_reg    <= w3_reg;
            last4_reg <= last3_reg;

            t5_reg    <= T_BITS'(p4_reg) * T_BITS'(w4_reg);
            last5_reg <= last4_reg;
        end
    end

    assign entry_valid = v5_reg;
    assign entry.last  = last5_reg;
    assign entry.term  = {{(SUM_BITS-T_BITS){1'b0}}, t5_reg};

endmodule

`default_nettype wire

// ===== design/ssi_queue.sv =====
// ----------------------------------------------------------------------------
// ssi_queue: small term queue
// Decouples the term pipeline from the accumulator. DEPTH of 2 or more.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_queue import ssi_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire ssi_entry_t push_entry,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output ssi_entry_t      pop_entry
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    ssi_entry_t           mem_reg [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 push, pop;

    assign push_ready = count_reg != CNT_BITS'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    assign wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("queue count above depth");

    a_count_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_count_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count missed a pop");

endmodule

`default_nettype wire

// ===== design/ssi_back.sv =====
// ----------------------------------------------------------------------------
// ssi_back: accumulator and normalizer
// Sums terms with saturation; on the last term scales the sum by the
// reciprocal area in states ST_MUL and ST_OUT and loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_back import ssi_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   entry_valid,
    output logic                        entry_ready,
    input  wire ssi_entry_t             entry,
    input  wire logic [AREA_BITS-1:0]   inv_total_area,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [RESULT_BITS-1:0]      m_tdata,
    output logic                        m_tuser
);

    localparam int HALF_BITS = SUM_BITS / 2;
    localparam int PROD_BITS = HALF_BITS + AREA_BITS;

    localparam logic [1:0] ST_ACC = 2'd0;
    localparam logic [1:0] ST_MUL = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [SUM_BITS-1:0]   sum_reg;
    logic                  clamp_reg;
    logic [SUM_BITS-1:0]   fin_sum_reg;
    logic                  fin_clamp_reg;
    logic [PROD_BITS-1:0]  lo_prod_reg;
    logic                  out_valid_reg;
    logic [RESULT_BITS-1:0] out_value_reg;
    logic                  out_sat_reg;

    logic                  pop, out_free, emit;
    logic [SUM_BITS:0]     add_ext;
    logic [SUM_BITS-1:0]   sum_add;
    logic                  clamp_add;
    logic [PROD_BITS:0]    lo_rnd;
    logic [PROD_BITS:0]    result;
    logic                  result_ovf;

    assign entry_ready = state_reg == ST_ACC;
    assign pop         = entry_valid && entry_ready;
    assign out_free    = !out_valid_reg || m_tready;
    assign emit        = (state_reg == ST_OUT) && out_free;

    // saturating add of one term
    assign add_ext   = {1'b0, sum_reg} + {1'b0, entry.term};
    assign sum_add   = add_ext[SUM_BITS] ? '1 : add_ext[SUM_BITS-1:0];
    assign clamp_add = clamp_reg || add_ext[SUM_BITS];

    // high half product plus rounded low half product
    assign lo_rnd = {1'b0, lo_prod_reg} + (PROD_BITS+1)'(33'h0_8000_0000);
    assign result = {1'b0, fin_sum_reg[SUM_BITS-1:HALF_BITS] * PROD_BITS'(inv_total_area)}
                  + (PROD_BITS+1)'(lo_rnd[PROD_BITS:HALF_BITS]);
    assign result_ovf = result[PROD_BITS:RESULT_BITS] != '0;

    always_comb begin
        case (state_reg)
            ST_ACC:  state_next = (pop && entry.last) ? ST_MUL : ST_ACC;
            ST_MUL:  state_next = ST_OUT;
            ST_OUT:  state_next = out_free ? ST_ACC : ST_OUT;
            default: state_next = ST_ACC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACC;
            sum_reg       <= '0;
            clamp_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop) begin
                if (entry.last) begin
                    sum_reg   <= '0;
                    clamp_reg <= 1'b0;
                end else begin
                    sum_reg   <= sum_add;
                    clamp_reg <= clamp_add;
                end
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && entry.last) begin
            fin_sum_reg   <= sum_add;
            fin_clamp_reg <= clamp_add;
        end
        if (state_reg == ST_MUL) begin
            lo_prod_reg <= fin_sum_reg[HALF_BITS-1:0] * PROD_BITS'(inv_total_area);
        end
        if (emit) begin
            out_value_reg <= result_ovf ? '1 : result[RESULT_BITS-1:0];
            out_sat_reg   <= fin_clamp_reg || result_ovf;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_sat_reg;

    a_mul_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |=> state_reg == ST_OUT)
        else $error("normalize step skipped");

    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && entry.last) |=> (sum_reg == '0) && !clamp_reg)
        else $error("sum not cleared after last term");

    a_clamp_full: assert property (@(posedge aclk) disable iff (!aresetn)
        clamp_reg |-> sum_reg == '1)
        else $error("clamp flag set on unsaturated sum");

endmodule

`default_nettype wire

// ===== design/scattering_source_integral.sv =====
// ----------------------------------------------------------------------------
// scattering_source_integral: Rayleigh phase scattering integral
// Sums phase factor times face mean times weight over a run of quadrature
// directions and emits the normalized, saturated integral on the last one.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per quadrature direction. tdata carries, from bit 0:
//   target_dir_x/y/z, quad_dir_x/y/z (Q1.14 signed), quad_weight (Q0.16),
//   face_illum_0..3 (ILLUM_BITS each), zero padding to a whole byte.
//   s_tlast marks the final direction of a sum.
//   m_ channel: one word per run, sent after the word with s_tlast.
//   m_tdata = scatter_value, m_tuser = saturated.
//   cfg channel: writes inv_total_area (Q0.16); cfg_ready is always high.
//   Write it only while no run is in flight.
// Timing: input words are taken one per cycle while the queue has room. A
//   five-stage term pipeline feeds a QUEUE_DEPTH-entry queue; the accumulator
//   takes one term per cycle while in ST_ACC; the last term sends it through
//   ST_MUL and ST_OUT to scale the sum (two 32x16 products), and it takes no
//   further terms until the result word is loaded into the output register.
// Reset (aresetn low): clears the sum, the clamp flag, the queue and all
//   valid flags; inv_total_area returns to 5215.
// Stall: a held result stays in the output register; terms keep summing
//   into the next run until the next last word, then the queue and the
//   pipeline fill and s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module scattering_source_integral import ssi_pkg::*; #(
    parameter int ILLUM_BITS  = ILLUM_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // input words
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // target_dir_x, target_dir_y, target_dir_z, quad_dir_x, quad_dir_y,
    // quad_dir_z, quad_weight, face_illum_0..3, zero pad
    input  wire logic [((HEAD_BITS + FACES_PER_CELL * ILLUM_BITS + 7) / 8) * 8 - 1:0]
                                            s_tdata,
    input  wire logic                       s_tlast,
    // result words
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [RESULT_BITS-1:0]          m_tdata,   // scatter_value
    output logic                            m_tuser,   // saturated
    // configuration write
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [AREA_BITS-1:0]       cfg_data
);

    localparam int DATA_BITS = ((HEAD_BITS + FACES_PER_CELL * ILLUM_BITS + 7) / 8) * 8;

    logic [AREA_BITS-1:0] inv_area_reg;
    logic                 push_valid, push_ready;
    ssi_entry_t           push_entry;
    logic                 pop_valid, pop_ready;
    ssi_entry_t           pop_entry;

    // configuration register: always ready, hold between writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_area_reg <= INV_AREA_RESET;
        end else if (cfg_valid && cfg_ready) begin
            inv_area_reg <= cfg_data;
        end
    end

    // front: form one weighted term per direction
    ssi_front #(
        .ILLUM_BITS (ILLUM_BITS),
        .DATA_BITS  (DATA_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .entry_valid (push_valid),
        .entry_ready (push_ready),
        .entry       (push_entry)
    );

    // queue: absorb the normalize cycles of the back end
    ssi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // back: accumulate, scale on the last term, drive the result word
    ssi_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .entry_valid    (pop_valid),
        .entry_ready    (pop_ready),
        .entry          (pop_entry),
        .inv_total_area (inv_area_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: scattering source integral testbench
// Streams runs of quadrature directions into the block and predicts each
// normalized integral from its own fixed-point copy of the phase-factor sum.
// Both bus sides stall at random, and the area reciprocal is rewritten
// between runs, including its extremes.
// ----------------------------------------------------------------------------
module tb_top;
    import ssi_pkg::*;

    localparam int ILLUM     = ILLUM_BITS_DEF;
    localparam int TDATA_W   = ((HEAD_BITS + FACES_PER_CELL * ILLUM + 7) / 8) * 8;
    localparam int SETTLE    = 20;       // cycles past the last result before a write
    localparam int LONG_HOLD = 100;      // receiver hold-off that backs up the input
    localparam int PHASE_LEN = 85;       // random words per area setting
    localparam longint LIMIT_NS = 3_000_000;

    localparam bit [DIR_BITS-1:0] Q14_ONE     = 16'h4000;
    localparam bit [DIR_BITS-1:0] Q14_NEG_ONE = 16'hC000;
    localparam bit [DIR_BITS-1:0] Q14_DIAG    = 16'd11585;   // about 1/sqrt(2)
    localparam bit [ILLUM-1:0]    FACE_MAX    = {ILLUM{1'b1}};
    localparam bit [WEIGHT_BITS-1:0] WEIGHT_MAX = {WEIGHT_BITS{1'b1}};

    // one quadrature direction word, as it goes onto the input bus
    typedef struct packed {
        bit                                     last;
        bit [FACES_PER_CELL-1:0][ILLUM-1:0]     face;
        bit [WEIGHT_BITS-1:0]                   weight;
        bit [DIR_BITS-1:0]                      qz, qy, qx;
        bit [DIR_BITS-1:0]                      tz, ty, tx;
    } quad_word_t;

    typedef struct packed {
        bit [RESULT_BITS-1:0] value;
        bit                   sat;
    } integral_t;

    // ------------------------------------------------------------------------
    // Fixed-point integral tracker: own copy of the running sum and the area
    // reciprocal, plus the sums that are due on the result bus.
    // ------------------------------------------------------------------------
    class integral_tracker;
        bit [SUM_BITS-1:0]  acc;
        bit                 clamped;
        bit [AREA_BITS-1:0] inv_area;
        integral_t          sums_due[$];
        int                 mismatches;
        int                 checked;
        int                 sat_count;

        function new();
            acc      = '0;
            clamped  = 1'b0;
            inv_area = INV_AREA_RESET;
        endfunction

        function void set_area(bit [AREA_BITS-1:0] v);
            inv_area = v;
        endfunction

        function void take_direction(quad_word_t w);
            longint    dot;
            bit [63:0] mag, m, g, fsum, mean, p, t, hi, lo, r, inv;
            integral_t res;
            dot = longint'($signed(w.tx)) * longint'($signed(w.qx))
                + longint'($signed(w.ty)) * longint'($signed(w.qy))
                + longint'($signed(w.tz)) * longint'($signed(w.qz));
            mag  = (dot < 0) ? 64'(-dot) : 64'(dot);
            m    = (mag + 64'd8192) >> 14;
            g    = (64'd3 * ((64'd1 << 28) + m * m) + 64'd32768) >> 16;
            fsum = '0;
            for (int k = 0; k < FACES_PER_CELL; k++)
                fsum += 64'(w.face[k]);
            mean = (fsum + FACES_PER_CELL / 2) / FACES_PER_CELL;
            p    = (g * mean + 64'd8192) >> 14;
            t    = p * 64'(w.weight);
            if (acc > ~64'd0 - t) begin
                acc     = ~64'd0;
                clamped = 1'b1;
            end else begin
                acc += t;
            end
            if (!w.last)
                return;
            inv = 64'(inv_area);
            hi  = acc >> 32;
            lo  = acc & 64'hFFFF_FFFF;
            r   = hi * inv + ((lo * inv + 64'h8000_0000) >> 32);
            res.sat = clamped;
            if (r > 64'hFFFF_FFFF) begin
                r       = 64'hFFFF_FFFF;
                res.sat = 1'b1;
            end
            res.value = r[RESULT_BITS-1:0];
            sums_due.push_back(res);
            acc     = '0;
            clamped = 1'b0;
        endfunction

        function void check_integral(bit [RESULT_BITS-1:0] value, bit sat);
            integral_t exp_res;
            if (sums_due.size() == 0) begin
                $display("%0t: result word with none due: expected none, actual value %h sat %b",
                         $time, value, sat);
                mismatches++;
                return;
            end
            exp_res = sums_due.pop_front();
            checked++;
            if (exp_res.sat)
                sat_count++;
            if (value !== exp_res.value) begin
                $display("%0t: scatter_value expected %h actual %h",
                         $time, exp_res.value, value);
                mismatches++;
            end
            if (sat !== exp_res.sat) begin
                $display("%0t: saturated expected %b actual %b", $time, exp_res.sat, sat);
                mismatches++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // target_dir_x/y/z, quad_dir_x/y/z, quad_weight, face_illum_0..3
    logic [TDATA_W-1:0]     s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [RESULT_BITS-1:0] m_tdata;    // scatter_value
    logic                   m_tuser;    // saturated
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [AREA_BITS-1:0]   cfg_data;

    integral_tracker tracker = new();

    // stall controls that the main sequence sets for the sender and the receiver
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    bit long_hold_req = 1'b0;

    int words_sent;
    int runs_sent;
    int area_writes;

    scattering_source_integral #(
        .ILLUM_BITS(ILLUM)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #(LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: check every accepted result word, then decide m_tready for
    // the next cycle. Values read right after the edge are the ones the
    // block saw at that edge.
    // ------------------------------------------------------------------------
    initial begin
        int rx_hold;
        rx_hold = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                tracker.check_integral(m_tdata, m_tuser);
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                // long hold-off: the pipeline and queue fill and s_tready drops
                long_hold_req = 1'b0;
                rx_hold = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
                rx_hold = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic quad_word_t quad_word(
        bit [15:0] tx, bit [15:0] ty, bit [15:0] tz,
        bit [15:0] qx, bit [15:0] qy, bit [15:0] qz, bit [15:0] weight,
        bit [ILLUM-1:0] f0, bit [ILLUM-1:0] f1, bit [ILLUM-1:0] f2,
        bit [ILLUM-1:0] f3, bit last);
        quad_word_t w;
        w.tx = tx; w.ty = ty; w.tz = tz;
        w.qx = qx; w.qy = qy; w.qz = qz;
        w.weight = weight;
        w.face   = {f3, f2, f1, f0};
        w.last   = last;
        return w;
    endfunction

    // direction component: extremes and zero often, else anywhere from -1.0 to +1.0
    function automatic bit [DIR_BITS-1:0] pick_comp();
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0: return Q14_ONE;
            1: return Q14_NEG_ONE;
            2: return '0;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic bit [WEIGHT_BITS-1:0] pick_weight();
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0: return '0;
            1: return WEIGHT_MAX;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit [ILLUM-1:0] pick_face();
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0: return FACE_MAX;
            1: return ILLUM'($urandom_range(0, 3));
            default: return ILLUM'($urandom);
        endcase
    endfunction

    // present one word and hold it until the block takes it
    task automatic send_word(quad_word_t w);
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({w.face, w.weight, w.qz, w.qy, w.qx, w.tz, w.ty, w.tx});
        s_tlast  <= w.last;
        do @(posedge aclk); while (!s_tready);
        tracker.take_direction(w);
        words_sent++;
        if (w.last)
            runs_sent++;
        // random gap after the word, on any phase of the block's work
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // one run for a single target direction; heavy runs are built to
    // overflow the scaled result
    task automatic send_run(int len, bit heavy);
        bit [DIR_BITS-1:0] tx, ty, tz;
        quad_word_t        w;
        if (heavy) begin
            tx = Q14_ONE; ty = Q14_ONE; tz = Q14_ONE;
        end else begin
            tx = pick_comp(); ty = pick_comp(); tz = pick_comp();
        end
        for (int i = 0; i < len; i++) begin
            if (heavy)
                w = quad_word(tx, ty, tz, Q14_ONE, Q14_ONE, Q14_ONE, WEIGHT_MAX,
                              FACE_MAX, FACE_MAX, FACE_MAX, FACE_MAX, i == len - 1);
            else
                w = quad_word(tx, ty, tz, pick_comp(), pick_comp(), pick_comp(),
                              pick_weight(), pick_face(), pick_face(), pick_face(),
                              pick_face(), i == len - 1);
            send_word(w);
        end
    endtask

    // hold the sender until every due sum has come back, then wait out the
    // SETTLE margin before anything else
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.sums_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_area(bit [AREA_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_area(v);
        area_writes++;
    endtask

    task automatic random_phase(int quota, bit heavy_first);
        int sent;
        int len;
        sent = 0;
        if (heavy_first) begin
            len = $urandom_range(36, 44);
            send_run(len, 1'b1);
            sent += len;
        end
        while (sent < quota) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            send_run(len, 1'b0);
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        bit [AREA_BITS-1:0] area_plan [6];

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        words_sent  = 0;
        runs_sent   = 0;
        area_writes = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed words, area still at its reset value
        // all zero
        send_word(quad_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        // parallel unit directions, full weight and faces
        send_word(quad_word(Q14_ONE, 0, 0, Q14_ONE, 0, 0, WEIGHT_MAX,
                            FACE_MAX, FACE_MAX, FACE_MAX, FACE_MAX, 1'b1));
        // perpendicular directions: factor 0.75
        send_word(quad_word(Q14_ONE, 0, 0, 0, Q14_ONE, 0, 16'h8000,
                            24'h800000, 24'h800000, 24'h800000, 24'h800000, 1'b1));
        // antiparallel: negative dot product
        send_word(quad_word(0, 0, Q14_NEG_ONE, 0, 0, Q14_ONE, 16'd1, 1, 2, 3, 4, 1'b1));
        // directions not of unit length, factor well above 1.5
        send_word(quad_word(Q14_ONE, Q14_ONE, Q14_ONE, Q14_ONE, Q14_ONE, Q14_ONE,
                            WEIGHT_MAX, FACE_MAX, FACE_MAX, FACE_MAX, FACE_MAX, 1'b1));
        send_word(quad_word(Q14_NEG_ONE, Q14_NEG_ONE, Q14_NEG_ONE, Q14_ONE, Q14_ONE,
                            Q14_ONE, WEIGHT_MAX, 24'h123456, 24'hFEDCBA, 0, FACE_MAX,
                            1'b1));
        // face mean rounding: 1/4 rounds down, 2/4 rounds up, 6/4 to 2
        send_word(quad_word(Q14_ONE, 0, 0, Q14_ONE, 0, 0, WEIGHT_MAX, 1, 0, 0, 0, 1'b1));
        send_word(quad_word(Q14_ONE, 0, 0, Q14_ONE, 0, 0, WEIGHT_MAX, 2, 0, 0, 0, 1'b1));
        send_word(quad_word(Q14_ONE, 0, 0, Q14_ONE, 0, 0, WEIGHT_MAX, 3, 1, 1, 1, 1'b1));
        // tiny components: dot rounds to zero
        send_word(quad_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF,
                            16'h5555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                            1'b1));
        // diagonal directions at right angles
        send_word(quad_word(Q14_DIAG, Q14_DIAG, 0, Q14_DIAG, 16'(-16'sd11585), 0,
                            16'h7FFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                            1'b1));
        // a run of four, one of them with zero weight
        send_word(quad_word(0, Q14_ONE, 0, 0, Q14_ONE, 0, WEIGHT_MAX,
                            FACE_MAX, 0, FACE_MAX, 0, 1'b0));
        send_word(quad_word(0, Q14_ONE, 0, Q14_NEG_ONE, 0, 0, 0,
                            FACE_MAX, FACE_MAX, FACE_MAX, FACE_MAX, 1'b0));
        send_word(quad_word(0, Q14_ONE, 0, 0, 16'h2000, 16'h2000, 16'h1234,
                            24'h00F00F, 24'h0F00F0, 24'hF00F00, 24'h0000FF, 1'b0));
        send_word(quad_word(0, Q14_ONE, 0, 0, Q14_NEG_ONE, 0, 16'h0001,
                            1, 1, 1, 1, 1'b1));

        // random runs over several area settings, extremes among them
        area_plan[0] = WEIGHT_MAX;              // full scale: heavy run saturates
        area_plan[1] = '0;                      // every integral scales to zero
        area_plan[2] = 16'($urandom);           // long receiver hold-off here
        area_plan[3] = 16'd1;
        area_plan[4] = 16'($urandom);
        area_plan[5] = INV_AREA_RESET;          // final part, no idling

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            write_area(area_plan[ph]);
            if (ph == 2) begin
                tx_gaps = 1'b0;
                long_hold_req = 1'b1;
            end
            if (ph == 5) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            random_phase(PHASE_LEN, ph == 0);
            if (ph == 2)
                tx_gaps = 1'b1;
        end

        wait_idle();

        $display("Sent %0d direction words in %0d runs over %0d area settings;",
                 words_sent, runs_sent, area_writes);
        $display("checked %0d integrals, %0d of them saturated, %0d mismatches.",
                 tracker.checked, tracker.sat_count, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.sums_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
